// ===== src/hub_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and the CORDIC arctangent function for the Hubeny distance block.
// No dependencies; hub_prep, hub_cordic and the top level import this package.
package hub_pkg;

  localparam int FRAC_BITS_DEF    = 30;
  localparam int CORDIC_STEPS_DEF = 32;

  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int DIST_W = 32;

  localparam logic [63:0] PI_Q61   = 64'h6487ED5110B4611A;
  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] K59      = PI_Q61 / 64'd720000000;
  localparam logic [63:0] E2_Q40   = 64'd7360548640;
  localparam logic [63:0] GAIN_Q40 = 64'd667681663043;

  localparam int               A_CM_W = 30;
  localparam logic [A_CM_W-1:0] A_CM  = 30'd637813700;

  // Final divider quotient width: large enough for any input before saturation.
  localparam int QUO2_W = 39;

  // atan(2^-i) in Q62, from the alternating series with truncating division.
  function automatic logic [63:0] atan_q62(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          k;
    int          e;
    acc = 64'd0;
    if (i == 0) begin
      return PI_Q60;
    end
    for (k = 0; i * (2 * k + 1) <= 62; k++) begin
      e    = 62 - i * (2 * k + 1);
      term = (64'd1 << e) / 64'(2 * k + 1);
      if ((k & 1) != 0) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

endpackage

// ===== src/hub_prep.sv =====
`timescale 1ns / 1ps
// Front end: coordinate differences, conversion to radians and latitude fold.
// Depends on hub_pkg. Three register stages.
module hub_prep import hub_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     vin,
  input  logic signed [LAT_W-1:0]  lat_first,
  input  logic signed [LON_W-1:0]  lon_first,
  input  logic signed [LAT_W-1:0]  lat_second,
  input  logic signed [LON_W-1:0]  lon_second,
  output logic                     vout,
  output logic [FRAC_BITS+4:0]     dlat,
  output logic [FRAC_BITS+4:0]     dlon,
  output logic signed [FRAC_BITS+3:0] z
);

  localparam int DW = FRAC_BITS + 5;
  localparam int PW = FRAC_BITS + 2;
  localparam int CW = FRAC_BITS + 4;
  localparam logic [63:0] HALFPI = PI_Q61 >> (62 - FRAC_BITS);
  localparam logic [63:0] PIQ    = PI_Q61 >> (61 - FRAC_BITS);

  logic [LAT_W:0] lat_diff, lat_sum;
  logic [LON_W:0] lon_diff;
  logic [LAT_W:0] lat_dm, lat_sm;
  logic [LON_W:0] lon_dm;
  logic           v1, v2;
  logic [63:0]    lat_prod, lon_prod, sum_prod;
  logic [DW-1:0]  dlat2, dlon2;
  logic [PW-1:0]  p2;
  logic [63:0]    zz;

  assign lat_diff = {lat_first[LAT_W-1], lat_first} - {lat_second[LAT_W-1], lat_second};
  assign lat_sum  = {lat_first[LAT_W-1], lat_first} + {lat_second[LAT_W-1], lat_second};
  assign lon_diff = {lon_first[LON_W-1], lon_first} - {lon_second[LON_W-1], lon_second};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      v2   <= v1;
      vout <= v2;
    end
  end

  // Stage 1: magnitudes; only the sizes of the differences and the sum matter.
  always_ff @(posedge clk) begin
    if (en) begin
      lat_dm <= lat_diff[LAT_W] ? -lat_diff : lat_diff;
      lat_sm <= lat_sum[LAT_W] ? -lat_sum : lat_sum;
      lon_dm <= lon_diff[LON_W] ? -lon_diff : lon_diff;
    end
  end

  // Stage 2: microdegrees to radians.
  assign lat_prod = 64'(lat_dm) * K59;
  assign lon_prod = 64'(lon_dm) * K59;
  assign sum_prod = 64'(lat_sm) * K59;

  always_ff @(posedge clk) begin
    if (en) begin
      dlat2 <= DW'(lat_prod >> (59 - FRAC_BITS));
      dlon2 <= DW'(lon_prod >> (59 - FRAC_BITS));
      p2    <= PW'(sum_prod >> (60 - FRAC_BITS));
    end
  end

  // Stage 3: a mean latitude past a right angle is folded to pi - P.
  assign zz = (64'(p2) > HALFPI) ? (PIQ - 64'(p2)) : 64'(p2);

  always_ff @(posedge clk) begin
    if (en) begin
      dlat <= dlat2;
      dlon <= dlon2;
      z    <= $signed(zz[CW-1:0]);
    end
  end

endmodule

// ===== src/hub_cordic.sv =====
`timescale 1ns / 1ps
// Rotation-mode CORDIC for sine and cosine, one register stage per iteration.
// Depends on hub_pkg for the gain and the arctangent table.
module hub_cordic import hub_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int SBW          = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vin,
  input  logic signed [FRAC_BITS+3:0] zin,
  input  logic [SBW-1:0]              sbin,
  output logic                        vout,
  output logic signed [FRAC_BITS+3:0] xout,
  output logic signed [FRAC_BITS+3:0] yout,
  output logic [SBW-1:0]              sbout
);

  localparam int CW = FRAC_BITS + 4;
  localparam logic [63:0] X0 = GAIN_Q40 >> (40 - FRAC_BITS);

  logic signed [CW-1:0] xs [CORDIC_STEPS+1];
  logic signed [CW-1:0] ys [CORDIC_STEPS+1];
  logic signed [CW-1:0] zs [CORDIC_STEPS+1];
  logic                 vs [CORDIC_STEPS+1];
  logic [SBW-1:0]       sb [CORDIC_STEPS+1];

  assign xs[0] = $signed(X0[CW-1:0]);
  assign ys[0] = '0;
  assign zs[0] = zin;
  assign vs[0] = vin;
  assign sb[0] = sbin;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic [63:0] AT64 = atan_q62(i) >> (62 - FRAC_BITS);
    localparam logic signed [CW-1:0] AT = $signed(AT64[CW-1:0]);

    logic signed [CW-1:0] x, y, zr;
    logic                 v;
    logic [SBW-1:0]       s;

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (en) begin
        v <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s <= sb[i];
        if (!zs[i][CW-1]) begin
          x  <= xs[i] - (ys[i] >>> i);
          y  <= ys[i] + (xs[i] >>> i);
          zr <= zs[i] - AT;
        end else begin
          x  <= xs[i] + (ys[i] >>> i);
          y  <= ys[i] - (xs[i] >>> i);
          zr <= zs[i] + AT;
        end
      end
    end

    assign xs[i+1] = x;
    assign ys[i+1] = y;
    assign zs[i+1] = zr;
    assign vs[i+1] = v;
    assign sb[i+1] = s;
  end

  assign vout  = vs[CORDIC_STEPS];
  assign xout  = xs[CORDIC_STEPS];
  assign yout  = ys[CORDIC_STEPS];
  assign sbout = sb[CORDIC_STEPS];

endmodule

// ===== src/hub_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// No dependencies. The top QW bits of the quotient must cover the answer (num >> QW < den).
module hub_div #(
  parameter int NW  = 65,
  parameter int DVW = 31,
  parameter int QW  = 36,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  logic [NW-1:0]  num,
  input  logic [DVW-1:0] den,
  input  logic [SBW-1:0] sbin,
  output logic           vout,
  output logic [QW-1:0]  quo,
  output logic [SBW-1:0] sbout
);

  logic [DVW-1:0] rem_a [QW+1];
  logic [DVW-1:0] den_a [QW+1];
  logic [QW-1:0]  low_a [QW+1];
  logic [QW-1:0]  q_a   [QW+1];
  logic           v_a   [QW+1];
  logic [SBW-1:0] sb_a  [QW+1];

  assign rem_a[0] = DVW'(num >> QW);
  assign den_a[0] = den;
  assign low_a[0] = num[QW-1:0];
  assign q_a[0]   = '0;
  assign v_a[0]   = vin;
  assign sb_a[0]  = sbin;

  for (genvar i = 0; i < QW; i++) begin : g_bit
    localparam int BI = QW - 1 - i;

    logic [DVW+1:0] diff;
    logic [DVW-1:0] rem_q, den_q;
    logic [QW-1:0]  low_q, q_q;
    logic           v_q;
    logic [SBW-1:0] sb_q;

    assign diff = {1'b0, rem_a[i], low_a[i][BI]} - {2'b00, den_a[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= v_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q <= den_a[i];
        low_q <= low_a[i];
        sb_q  <= sb_a[i];
        if (!diff[DVW+1]) begin
          rem_q <= diff[DVW-1:0];
          q_q   <= {q_a[i][QW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_a[i][DVW-2:0], low_a[i][BI]};
          q_q   <= {q_a[i][QW-2:0], 1'b0};
        end
      end
    end

    assign rem_a[i+1] = rem_q;
    assign den_a[i+1] = den_q;
    assign low_a[i+1] = low_q;
    assign q_a[i+1]   = q_q;
    assign v_a[i+1]   = v_q;
    assign sb_a[i+1]  = sb_q;
  end

  assign vout  = v_a[QW];
  assign quo   = q_a[QW];
  assign sbout = sb_a[QW];

endmodule

// ===== src/hub_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined floor square root, one root bit per register stage (remainder method).
// No dependencies.
module hub_sqrt #(
  parameter int XW  = 73,
  parameter int SBW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vin,
  input  logic [XW-1:0]        rad,
  input  logic [SBW-1:0]       sbin,
  output logic                 vout,
  output logic [(XW+1)/2-1:0]  root,
  output logic [SBW-1:0]       sbout
);

  localparam int RW = (XW + 1) / 2;
  localparam int TW = 2 * RW + 1;

  logic [TW-1:0]  rem_a [RW+1];
  logic [RW-1:0]  r_a   [RW+1];
  logic           v_a   [RW+1];
  logic [SBW-1:0] sb_a  [RW+1];

  assign rem_a[0] = TW'(rad);
  assign r_a[0]   = '0;
  assign v_a[0]   = vin;
  assign sb_a[0]  = sbin;

  for (genvar j = 0; j < RW; j++) begin : g_bit
    localparam int B = RW - 1 - j;

    logic [TW-1:0]  trial;
    logic [TW-1:0]  rem_q;
    logic [RW-1:0]  r_q;
    logic           v_q;
    logic [SBW-1:0] sb_q;

    // (r + 2^B)^2 - r^2, with r holding only bits above B.
    assign trial = (TW'(r_a[j]) << (B + 1)) | (TW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= v_a[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_q <= sb_a[j];
        if (trial <= rem_a[j]) begin
          rem_q <= rem_a[j] - trial;
          r_q   <= r_a[j] | (RW'(1) << B);
        end else begin
          rem_q <= rem_a[j];
          r_q   <= r_a[j];
        end
      end
    end

    assign rem_a[j+1] = rem_q;
    assign r_a[j+1]   = r_q;
    assign v_a[j+1]   = v_q;
    assign sb_a[j+1]  = sb_q;
  end

  assign vout  = v_a[RW];
  assign root  = r_a[RW];
  assign sbout = sb_a[RW];

endmodule

// ===== src/ellipsoid_distance_hubeny_top.sv =====
`timescale 1ns / 1ps
// Hubeny distance on the WGS84 ellipsoid, top level.
// Depends on hub_pkg, hub_prep, hub_cordic, hub_div and hub_sqrt.
//
// Usage: an input transaction carries two points (latitude and longitude in
// signed microdegrees); each produces exactly one output transaction with the
// distance in centimeters, rounded to nearest and saturated at 2^32-1.
// Both channels use valid/ready. A transaction is accepted whenever in_valid
// and in_ready are high at a clock edge.
// Throughput: one transaction per cycle while in_ready is high. The datapath
// is a single pipeline: front end (3), CORDIC (CORDIC_STEPS), products (4),
// first divider (FRAC_BITS+6), squares (2), hypotenuse root (FRAC_BITS+7),
// root of W^2 (FRAC_BITS+1), scaling (2), final divider (39) and the output
// register (1).
// When out_ready is low the result waits in the output register and the
// pipeline keeps moving until its last stage also holds a result; only then
// in_ready falls. Nothing is dropped or repeated across a stall.
// Reset (rst, synchronous) empties the pipeline and the output register.
module ellipsoid_distance_hubeny_top import hub_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [LAT_W-1:0] lat_first,
  input  logic signed [LON_W-1:0] lon_first,
  input  logic signed [LAT_W-1:0] lat_second,
  input  logic signed [LON_W-1:0] lon_second,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DIST_W-1:0]       distance_cm
);

  localparam int F    = FRAC_BITS;
  localparam int CW   = F + 4;
  localparam int DW   = F + 5;
  localparam int SW   = F + 2;
  localparam int W2W  = F + 1;
  localparam int T1W  = F + 5;
  localparam int BVW  = F + 6;
  localparam int AVW  = F + 6;
  localparam int N1W  = T1W + F;
  localparam int XW   = 2 * AVW + 1;
  localparam int RRW  = (XW + 1) / 2;
  localparam int WXW  = W2W + F;
  localparam int WRW  = (WXW + 1) / 2;
  localparam int PRW  = A_CM_W + RRW;
  localparam int N2W  = PRW + 1;

  localparam logic [63:0] ONE64    = 64'd1 << F;
  localparam logic [63:0] E2Q64    = E2_Q40 >> (40 - F);
  localparam logic [W2W-1:0] ONE   = ONE64[W2W-1:0];
  localparam logic [W2W-1:0] E2Q   = E2Q64[W2W-1:0];
  localparam logic [W2W-1:0] OME2  = ONE - E2Q;

  logic en, load;

  // Front end
  logic              pv;
  logic [DW-1:0]     p_dlat, p_dlon;
  logic signed [CW-1:0] p_z;

  // CORDIC
  logic              cv;
  logic signed [CW-1:0] cx, cy;
  logic [2*DW-1:0]   c_sb;

  // Product stages
  logic              v1, v2, v3, v4;
  logic [CW-1:0]     x_mag, y_mag;
  logic [SW-1:0]     s1, c1;
  logic [DW-1:0]     dlat1, dlon1;
  logic [2*SW-1:0]   s2_prod;
  logic [DW+W2W-1:0] t1_prod;
  logic [DW+SW-1:0]  bv_prod;
  logic [SW-1:0]     s2;
  logic [T1W-1:0]    t1_2, t1_3;
  logic [BVW-1:0]    bv2, bv3, bv4;
  logic [W2W+SW-1:0] t_prod;
  logic [SW-1:0]     t3;
  logic [W2W-1:0]    w2_4;
  logic [N1W-1:0]    num1;

  // First divider
  logic              dv1;
  logic [AVW-1:0]    av;
  logic [BVW+W2W-1:0] d1_sb;

  // Squares
  logic              v5, v6;
  logic [2*AVW-1:0]  sqa, sqb;
  logic [W2W-1:0]    w2_5, w2_6;
  logic [XW-1:0]     hyp2;

  // Roots
  logic              rv, wv;
  logic [RRW-1:0]    r_root, r_w;
  logic [W2W-1:0]    r_sb;
  logic [WRW-1:0]    w_root;

  // Scaling and final divider
  logic              v7, v8, dv2;
  logic [PRW-1:0]    prod7;
  logic [WRW-1:0]    w7, w8;
  logic [N2W-1:0]    num8;
  logic [QUO2_W-1:0] q2;

  assign load     = !out_valid || out_ready;
  assign en       = !dv2 || load;
  assign in_ready = en;

  hub_prep #(.FRAC_BITS(F)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .vin       (in_valid),
    .lat_first (lat_first),
    .lon_first (lon_first),
    .lat_second(lat_second),
    .lon_second(lon_second),
    .vout      (pv),
    .dlat      (p_dlat),
    .dlon      (p_dlon),
    .z         (p_z)
  );

  hub_cordic #(.FRAC_BITS(F), .CORDIC_STEPS(CORDIC_STEPS), .SBW(2 * DW)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (pv),
    .zin  (p_z),
    .sbin ({p_dlat, p_dlon}),
    .vout (cv),
    .xout (cx),
    .yout (cy),
    .sbout(c_sb)
  );

  assign x_mag = cx[CW-1] ? CW'(-cx) : CW'(cx);
  assign y_mag = cy[CW-1] ? CW'(-cy) : CW'(cy);

  assign s2_prod = (2 * SW)'(s1) * (2 * SW)'(s1);
  assign t1_prod = (DW + W2W)'(dlat1) * (DW + W2W)'(OME2);
  assign bv_prod = (DW + SW)'(dlon1) * (DW + SW)'(c1);
  assign t_prod  = (W2W + SW)'(E2Q) * (W2W + SW)'(s2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v1 <= cv;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= dv1;
      v6 <= v5;
      v7 <= wv;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // sine and cosine magnitudes
      s1    <= y_mag[SW-1:0];
      c1    <= x_mag[SW-1:0];
      dlat1 <= c_sb[2*DW-1:DW];
      dlon1 <= c_sb[DW-1:0];
      // sin^2, dLat*(1-e2), dLon*cos
      s2    <= SW'(s2_prod >> F);
      t1_2  <= T1W'(t1_prod >> F);
      bv2   <= BVW'(bv_prod >> F);
      // e2*sin^2
      t3    <= SW'(t_prod >> F);
      t1_3  <= t1_2;
      bv3   <= bv2;
      // W^2 = 1 - e2*sin^2, never below one LSB
      w2_4  <= ((W2W + 1)'(t3) < (W2W + 1)'(ONE)) ? (ONE - W2W'(t3)) : W2W'(1);
      num1  <= {t1_3, {F{1'b0}}};
      bv4   <= bv3;
    end
  end

  // A = dLat*(1-e2)/W^2
  hub_div #(.NW(N1W), .DVW(W2W), .QW(AVW), .SBW(BVW + W2W)) u_div_a (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (v4),
    .num  (num1),
    .den  (w2_4),
    .sbin ({bv4, w2_4}),
    .vout (dv1),
    .quo  (av),
    .sbout(d1_sb)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sqa  <= (2 * AVW)'(av) * (2 * AVW)'(av);
      sqb  <= (2 * AVW)'(d1_sb[BVW+W2W-1:W2W]) * (2 * AVW)'(d1_sb[BVW+W2W-1:W2W]);
      w2_5 <= d1_sb[W2W-1:0];
      hyp2 <= XW'(sqa) + XW'(sqb);
      w2_6 <= w2_5;
    end
  end

  hub_sqrt #(.XW(XW), .SBW(W2W)) u_sqrt_r (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (v6),
    .rad  (hyp2),
    .sbin (w2_6),
    .vout (rv),
    .root (r_root),
    .sbout(r_sb)
  );

  hub_sqrt #(.XW(WXW), .SBW(RRW)) u_sqrt_w (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (rv),
    .rad  ({r_sb, {F{1'b0}}}),
    .sbin (r_root),
    .vout (wv),
    .root (w_root),
    .sbout(r_w)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      prod7 <= PRW'(A_CM) * PRW'(r_w);
      w7    <= (w_root == '0) ? WRW'(1) : w_root;
      // add half of W so that the division rounds to nearest
      num8  <= N2W'(prod7) + N2W'(w7 >> 1);
      w8    <= w7;
    end
  end

  hub_div #(.NW(N2W), .DVW(WRW), .QW(QUO2_W), .SBW(1)) u_div_d (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (v8),
    .num  (num8),
    .den  (w8),
    .sbin (1'b0),
    .vout (dv2),
    .quo  (q2),
    .sbout()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= dv2;
    end
  end

  always_ff @(posedge clk) begin
    if (load && dv2) begin
      distance_cm <= (|q2[QUO2_W-1:DIST_W]) ? '1 : q2[DIST_W-1:0];
    end
  end

endmodule

// ===== sim/hubeny_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Hubeny distance block: watches both channels, predicts each
// distance in fixed point and compares it with the output. Depends on hub_pkg.
module hubeny_checker import hub_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [LAT_W-1:0] lat_first,
  input  logic signed [LON_W-1:0] lon_first,
  input  logic signed [LAT_W-1:0] lat_second,
  input  logic signed [LON_W-1:0] lon_second,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [DIST_W-1:0]       distance_cm,
  output int                      fail_count,
  output int                      pending
);
  localparam int FB = 30;
  localparam int STEPS = 32;

  logic [DIST_W-1:0] dist_expected[$];

  function automatic logic [63:0] arctan_q62(int i);
    logic [63:0] acc;
    logic [63:0] term;
    int k;
    acc = 0;
    if (i == 0) return PI_Q60;
    for (k = 0; i * (2 * k + 1) <= 62; k++) begin
      term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
      if (k & 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic logic [63:0] mul_fix(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[FB+63:FB];
  endfunction

  function automatic logic [63:0] root128(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] cand;
    int b;
    r = 0;
    for (b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= v) r = cand;
    end
    return r;
  endfunction

  function automatic logic [63:0] magn(longint d);
    return d < 0 ? 64'(-d) : 64'(d);
  endfunction

  function automatic logic [DIST_W-1:0] hubeny_cm(longint la1, longint lo1,
                                                 longint la2, longint lo2);
    logic [63:0] one, dlat, dlon, p, halfpi, piq, s, c, s2, t, w2, e2q, av, bv;
    logic [63:0] r, w, quo;
    logic [127:0] wide, sum;
    longint x, y, z, dx, dy, at;
    one = 64'd1 << FB;
    dlat = (magn(la1 - la2) * K59) >> (59 - FB);
    dlon = (magn(lo1 - lo2) * K59) >> (59 - FB);
    p = (magn(la1 + la2) * K59) >> (60 - FB);
    halfpi = PI_Q61 >> (62 - FB);
    piq = PI_Q61 >> (61 - FB);
    if (p > halfpi) p = piq - p;
    x = longint'(GAIN_Q40 >> (40 - FB));
    y = 0;
    z = longint'(p);
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      at = longint'(arctan_q62(i) >> (62 - FB));
      if (z >= 0) begin
        x -= dx; y += dy; z -= at;
      end else begin
        x += dx; y -= dy; z += at;
      end
    end
    s = magn(y);
    c = magn(x);
    e2q = E2_Q40 >> (40 - FB);
    s2 = mul_fix(s, s);
    t = mul_fix(e2q, s2);
    w2 = t < one ? one - t : 64'd1;
    t = mul_fix(dlat, one - e2q);
    av = 64'((128'(t) << FB) / 128'(w2));
    bv = mul_fix(dlon, c);
    sum = 128'(av) * 128'(av) + 128'(bv) * 128'(bv);
    r = root128(sum);
    w = root128(128'(w2) << FB);
    if (w == 0) w = 1;
    wide = 128'(A_CM) * 128'(r) + 128'(w >> 1);
    quo = 64'(wide / 128'(w));
    return quo > 64'hFFFFFFFF ? 32'hFFFFFFFF : quo[31:0];
  endfunction

  assign pending = dist_expected.size();

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
      dist_expected.delete();
    end else begin
      if (in_valid && in_ready)
        dist_expected.push_back(hubeny_cm(lat_first, lon_first, lat_second, lon_second));
      if (out_valid && out_ready) begin
        if (dist_expected.size() == 0) begin
          if (fail_count < 10) $display("unexpected output transaction: %0d", distance_cm);
          fail_count <= fail_count + 1;
        end else begin
          if (distance_cm !== dist_expected[0]) begin
            if (fail_count < 10)
              $display("distance_cm mismatch: expected %0d, got %0d",
                       dist_expected[0], distance_cm);
            fail_count <= fail_count + 1;
          end
          void'(dist_expected.pop_front());
        end
      end
    end
  end
endmodule

// ===== sim/tb_ellipsoid_distance_hubeny_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the Hubeny distance block: drives point pairs and output
// back-pressure. Depends on hub_pkg, the block and hubeny_checker.
module tb_ellipsoid_distance_hubeny_top;
  import hub_pkg::*;

  localparam int RANDOM_PAIRS = 1750;
  localparam int LATENCY = 187;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [LAT_W-1:0] lat_first = 0, lat_second = 0;
  logic signed [LON_W-1:0] lon_first = 0, lon_second = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [DIST_W-1:0] distance_cm;
  int fail_count;
  int pending;
  bit hold_long = 0;
  bit calm = 0;

  ellipsoid_distance_hubeny_top u_dut (.*);

  hubeny_checker u_chk (.*);

  initial forever #5 clk = ~clk;

  function automatic logic [LAT_W-1:0] pick_lat();
    case ($urandom_range(0, 5))
      0: return LAT_W'($urandom);
      1: return $urandom_range(0, 1) ? LAT_W'(90000000) : -LAT_W'(90000000);
      default: return LAT_W'(int'($urandom_range(0, 180000000)) - 90000000);
    endcase
  endfunction

  function automatic logic [LON_W-1:0] pick_lon();
    case ($urandom_range(0, 5))
      0: return LON_W'($urandom);
      1: return $urandom_range(0, 1) ? LON_W'(180000000) : -LON_W'(180000000);
      default: return LON_W'(int'($urandom_range(0, 360000000)) - 180000000);
    endcase
  endfunction

  // Offers one transaction and holds it until accepted.
  task automatic send_pair(logic [LAT_W-1:0] la1, logic [LON_W-1:0] lo1,
                           logic [LAT_W-1:0] la2, logic [LON_W-1:0] lo2);
    lat_first <= la1;
    lon_first <= lo1;
    lat_second <= la2;
    lon_second <= lo2;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic maybe_gap();
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 13);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 0;
        repeat (600) @(posedge clk);
        hold_long = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_ready <= 0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int waited;
    logic [LAT_W-1:0] near_lat;
    logic [LON_W-1:0] near_lon;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed corners: zero, poles, antimeridian, full-width extremes, one-microdegree steps.
    send_pair(0, 0, 0, 0);
    send_pair(90000000, 0, -90000000, 0);
    send_pair(0, -180000000, 0, 180000000);
    send_pair(90000000, 180000000, 90000000, -180000000);
    send_pair(-90000000, -180000000, 90000000, 180000000);
    send_pair(45000000, 10000000, 45000001, 10000001);
    send_pair(-45000000, 10000000, -45000001, 10000000);
    send_pair(89999999, 0, 89999999, 1);
    send_pair(28'sh7FFFFFF, 29'sh0FFFFFFF, 28'sh8000000, 29'sh10000000);
    send_pair(28'sh8000000, 29'sh10000000, 28'sh8000000, 29'sh10000000);
    send_pair(28'sh7FFFFFF, 0, 28'sh7FFFFFF, 29'sh10000000);
    send_pair(28'sh8000000, 29'sh0FFFFFFF, 28'sh8000000, 29'sh10000000);
    send_pair(60000000, 0, 60000000, 1);
    send_pair(0, 0, 1, 0);
    send_pair(35681236, 139767125, 34702485, 135495951);
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == 300) hold_long = 1;
      if (i == RANDOM_PAIRS - 200) calm = 1;
      maybe_gap();
      if ($urandom_range(0, 3) == 0) begin
        // Nearby points: short distances where rounding matters.
        near_lat = pick_lat();
        near_lon = pick_lon();
        send_pair(near_lat, near_lon,
                  near_lat + LAT_W'(int'($urandom_range(0, 2000)) - 1000),
                  near_lon + LON_W'(int'($urandom_range(0, 2000)) - 1000));
      end else begin
        send_pair(pick_lat(), pick_lon(), pick_lat(), pick_lon());
      end
    end
    in_valid <= 0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/hub_pkg.sv
src/hub_prep.sv
src/hub_cordic.sv
src/hub_div.sv
src/hub_sqrt.sv
src/ellipsoid_distance_hubeny_top.sv
sim/hubeny_checker.sv
sim/tb_ellipsoid_distance_hubeny_top.sv
